[rtl/core/kbs_pkg.sv]
// Shared types and constants for the keyframe bone sampler.
// Holds the command and result words and the internal command format.
// Depends on nothing.
package kbs_pkg;

	localparam int DEF_MAX_KEYS  = 16;
	localparam int DEF_MAX_BONES = 16;

	// Width of one stored vector, x in the top 32 bits, z in the bottom.
	localparam int VEC_W = 96;
	// Key memory word: rotation present, position present, rotation, position.
	localparam int KEY_W = 2 + 2 * VEC_W;

	localparam logic [1:0] FUNC_COMMIT    = 2'd0;
	localparam logic [1:0] FUNC_STAGE_ROT = 2'd1;
	localparam logic [1:0] FUNC_STAGE_POS = 2'd2;
	localparam logic [1:0] FUNC_SAMPLE    = 2'd3;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NOKEY = 2'd1;
	localparam logic [1:0] STAT_NOROT = 2'd2;
	localparam logic [1:0] STAT_FULL  = 2'd3;

	localparam logic [1:0] REG_LOOP_ADDR = 2'd0;

	typedef enum logic [1:0] {
		OP_COMMIT    = 2'd0,
		OP_STAGE_ROT = 2'd1,
		OP_STAGE_POS = 2'd2,
		OP_SAMPLE    = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] time_value;
		logic [3:0]         bone_index;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
	} in_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] rot_x;
		logic signed [31:0] rot_y;
		logic signed [31:0] rot_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} out_word_t;

	typedef struct packed {
		op_t                op;
		logic               bone_ok;
		logic [3:0]         bone_index;
		logic signed [31:0] time_value;
		logic [VEC_W-1:0]   vec;
	} cmd_t;

endpackage

[rtl/core/kbs_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read.
// Depends on nothing.
module kbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/kbs_front.sv]
// Front end: takes command words, classifies them and queues them for the back end.
// Depends on kbs_pkg.
module kbs_front
	import kbs_pkg::*;
#(
	parameter int MAX_BONES = DEF_MAX_BONES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  in_word_t cmd,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output cmd_t     cmd_out
);

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] level_q;
	logic       push;
	logic       pop;
	cmd_t       cls;

	always_comb begin
		cls = '0;
		unique case (cmd.func)
			FUNC_COMMIT:    cls.op = OP_COMMIT;
			FUNC_STAGE_ROT: cls.op = OP_STAGE_ROT;
			FUNC_STAGE_POS: cls.op = OP_STAGE_POS;
			FUNC_SAMPLE:    cls.op = OP_SAMPLE;
			default:        cls.op = OP_SAMPLE;
		endcase
		cls.bone_ok    = {28'd0, cmd.bone_index} < 32'(MAX_BONES);
		cls.bone_index = cmd.bone_index;
		cls.time_value = cmd.time_value;
		cls.vec        = {cmd.vec_x, cmd.vec_y, cmd.vec_z};
	end

	assign busy      = (level_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (level_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd_out   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				level_q <= level_q + 2'd1;
			end else if (pop && !push) begin
				level_q <= level_q - 2'd1;
			end
		end
	end

endmodule

[rtl/core/kbs_back.sv]
// Back end: keyframe table, staging frame and the sampling sequencer.
// Depends on kbs_pkg and kbs_ram.
module kbs_back
	import kbs_pkg::*;
#(
	parameter int MAX_KEYS  = DEF_MAX_KEYS,
	parameter int MAX_BONES = DEF_MAX_BONES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      loop_enable,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	output logic      result_valid,
	output out_word_t result
);

	localparam int KW = $clog2(MAX_KEYS);
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int BW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
	localparam int KDEPTH = MAX_KEYS * (1 << BW);
	localparam int SDEPTH = 1 << BW;

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_CM_INS  = 11'b000_0000_0010,
		S_CM_COPY = 11'b000_0000_0100,
		S_MOD     = 11'b000_0000_1000,
		S_CLAMP   = 11'b000_0001_0000,
		S_SRCH    = 11'b000_0010_0000,
		S_RD0     = 11'b000_0100_0000,
		S_RD1     = 11'b000_1000_0000,
		S_RD2     = 11'b001_0000_0000,
		S_DIV     = 11'b010_0000_0000,
		S_MUL     = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;

	logic [CW-1:0]      count_q;
	logic signed [31:0] time_row_q [MAX_KEYS];
	logic [KW-1:0]      slot_row_q [MAX_KEYS];
	logic [MAX_BONES-1:0] stage_rp_q;
	logic [MAX_BONES-1:0] stage_pp_q;
	logic [KW-1:0]      new_slot_q;

	logic [BW:0]   bc_q;
	logic          copy_v_s1;
	logic [BW-1:0] copy_b_s1;

	logic signed [31:0] tm_q;
	logic signed [31:0] dur_q;
	logic [31:0]        mod_a_q;
	logic [32:0]        mod_r_q;
	logic               mod_neg_q;
	logic [5:0]         step_q;
	logic [KW-1:0]      pv_q;
	logic [KW-1:0]      nx_q;

	logic [KEY_W-1:0] key_a_q;
	logic [KEY_W-1:0] key_b_q;
	logic [33:0]      div_r_q;
	logic [33:0]      span_q;
	logic [15:0]      t_q;

	logic [2:0]         mc_q;
	logic               mul_v_s1;
	logic [2:0]         comp_s1;
	logic signed [49:0] prod_s1;
	logic signed [31:0] a_s1;
	logic signed [31:0] b_s1;
	logic [1:0]         pick_s1;

	out_word_t res_q;
	logic      valid_q;

	// Insertion cells
	logic               le     [MAX_KEYS];
	logic               le_prev[MAX_KEYS];
	logic signed [31:0] t_prev [MAX_KEYS];
	logic [KW-1:0]      s_prev [MAX_KEYS];

	// Memories
	logic [KEY_W-1:0] kram_rdata;
	logic [KEY_W-1:0] kram_wdata;
	logic [KW+BW-1:0] kram_raddr;
	logic             kram_we;
	logic [VEC_W-1:0] srot_rdata;
	logic [VEC_W-1:0] spos_rdata;
	logic             srot_we;
	logic             spos_we;

	logic [BW-1:0]      bone_in;
	logic [BW-1:0]      bone_q;
	logic [KW-1:0]      cnt_m1;
	logic signed [31:0] dur_w;
	logic [KW-1:0]      pv_inc;
	logic [32:0]        mod_sh;
	logic [32:0]        mod_d;
	logic [32:0]        mod_nx;
	logic signed [31:0] tm_c;
	logic [33:0]        div_sh;
	logic signed [32:0] span_w;
	logic signed [32:0] rem_w;
	logic signed [31:0] a_comp [8];
	logic signed [31:0] b_comp [8];
	logic [1:0]         pick_c [8];
	logic signed [32:0] diff_w;
	logic signed [33:0] q_w;
	logic signed [31:0] lerp_w;
	logic [KEY_W-1:0]   key_b;

	assign bone_in = BW'(cmd.bone_index);
	assign bone_q  = BW'(cmd_q.bone_index);
	assign cnt_m1  = KW'(count_q - CW'(1));
	assign dur_w   = time_row_q[cnt_m1];
	assign pv_inc  = pv_q + KW'(1);
	assign cmd_ready = (state_q == S_IDLE);

	always_comb begin
		for (int i = 0; i < MAX_KEYS; i++) begin
			le[i] = (CW'(i) < count_q) && !(time_row_q[i] > cmd_q.time_value);
		end
		le_prev[0] = 1'b1;
		t_prev[0]  = time_row_q[0];
		s_prev[0]  = slot_row_q[0];
		for (int i = 1; i < MAX_KEYS; i++) begin
			le_prev[i] = le[i-1];
			t_prev[i]  = time_row_q[i-1];
			s_prev[i]  = slot_row_q[i-1];
		end
	end

	assign mod_sh = {mod_r_q[31:0], mod_a_q[31]};
	assign mod_d  = {1'b0, dur_q};
	assign mod_nx = (mod_sh >= mod_d) ? (mod_sh - mod_d) : mod_sh;

	always_comb begin
		tm_c = (tm_q < 0) ? 32'sd0 : tm_q;
		if (tm_c > dur_q) begin
			tm_c = dur_q;
		end
	end

	assign div_sh = {div_r_q[32:0], 1'b0};

	// In the last read cycle the second key's word is still on the RAM output.
	assign key_b  = kram_rdata;
	assign span_w = 33'(time_row_q[nx_q]) - 33'(time_row_q[pv_q]);
	assign rem_w  = 33'(tm_q) - 33'(time_row_q[pv_q]);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			a_comp[c]   = key_a_q[2*VEC_W-1-32*c -: 32];
			b_comp[c]   = key_b_q_sel(c);
			a_comp[c+3] = key_a_q[VEC_W-1-32*c -: 32];
			b_comp[c+3] = key_b_q_sel(c + 3);
			pick_c[c]   = {key_a_q[KEY_W-1], key_b_q[KEY_W-1]};
			pick_c[c+3] = {key_a_q[KEY_W-2], key_b_q[KEY_W-2]};
		end
		a_comp[6] = '0;
		a_comp[7] = '0;
		b_comp[6] = '0;
		b_comp[7] = '0;
		pick_c[6] = '0;
		pick_c[7] = '0;
	end

	function automatic logic signed [31:0] key_b_q_sel(input int c);
		logic signed [31:0] v;
		if (c < 3) begin
			v = key_b_q[2*VEC_W-1-32*c -: 32];
		end else begin
			v = key_b_q[VEC_W-1-32*(c-3) -: 32];
		end
		return v;
	endfunction

	assign diff_w = 33'(b_comp[mc_q]) - 33'(a_comp[mc_q]);
	assign q_w    = prod_s1[49:16];
	assign lerp_w = 32'(34'(a_s1) + q_w);

	assign kram_we    = copy_v_s1;
	assign kram_wdata = {stage_rp_q[copy_b_s1], stage_pp_q[copy_b_s1], srot_rdata, spos_rdata};
	assign kram_raddr = (state_q == S_RD0) ? {slot_row_q[pv_q], bone_q}
	                                       : {slot_row_q[nx_q], bone_q};
	assign srot_we = (state_q == S_IDLE) && cmd_valid && (cmd.op == OP_STAGE_ROT) && cmd.bone_ok;
	assign spos_we = (state_q == S_IDLE) && cmd_valid && (cmd.op == OP_STAGE_POS) && cmd.bone_ok;

	kbs_ram #(.WIDTH(KEY_W), .DEPTH(KDEPTH)) u_key_ram (
		.clk   (clk),
		.we    (kram_we),
		.waddr ({new_slot_q, copy_b_s1}),
		.wdata (kram_wdata),
		.raddr (kram_raddr),
		.rdata (kram_rdata)
	);

	kbs_ram #(.WIDTH(VEC_W), .DEPTH(SDEPTH)) u_stage_rot (
		.clk   (clk),
		.we    (srot_we),
		.waddr (bone_in),
		.wdata (cmd.vec),
		.raddr (bc_q[BW-1:0]),
		.rdata (srot_rdata)
	);

	kbs_ram #(.WIDTH(VEC_W), .DEPTH(SDEPTH)) u_stage_pos (
		.clk   (clk),
		.we    (spos_we),
		.waddr (bone_in),
		.wdata (cmd.vec),
		.raddr (bc_q[BW-1:0]),
		.rdata (spos_rdata)
	);

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			cmd_q <= cmd;
			dur_q <= dur_w;
			tm_q  <= cmd.time_value;
			mod_neg_q <= cmd.time_value < 0;
			mod_a_q   <= (cmd.time_value < 0) ? 32'(-cmd.time_value) : cmd.time_value;
			mod_r_q <= '0;
		end
		if (state_q == S_CM_INS) begin
			for (int i = 0; i < MAX_KEYS; i++) begin
				if (!le[i]) begin
					if (le_prev[i]) begin
						time_row_q[i] <= cmd_q.time_value;
						slot_row_q[i] <= new_slot_q;
					end else begin
						time_row_q[i] <= t_prev[i];
						slot_row_q[i] <= s_prev[i];
					end
				end
			end
		end
		if (state_q == S_MOD) begin
			mod_r_q <= mod_nx;
			mod_a_q <= {mod_a_q[30:0], 1'b0};
			if (step_q == 6'd31) begin
				tm_q <= mod_neg_q ? -$signed(mod_nx[31:0]) : $signed(mod_nx[31:0]);
			end
		end
		if (state_q == S_CLAMP) begin
			tm_q <= tm_c;
		end
		if (state_q == S_RD1) begin
			key_a_q <= kram_rdata;
		end
		if (state_q == S_RD2) begin
			key_b_q <= kram_rdata;
			span_q  <= 34'(span_w);
			div_r_q <= 34'(rem_w);
			t_q     <= '0;
		end
		if (state_q == S_DIV) begin
			if (div_sh >= span_q) begin
				div_r_q <= div_sh - span_q;
				t_q     <= {t_q[14:0], 1'b1};
			end else begin
				div_r_q <= div_sh;
				t_q     <= {t_q[14:0], 1'b0};
			end
		end
		prod_s1 <= diff_w * $signed({1'b0, t_q});
		a_s1    <= a_comp[mc_q];
		b_s1    <= b_comp[mc_q];
		pick_s1 <= pick_c[mc_q];
		comp_s1 <= mc_q;
		copy_b_s1 <= bc_q[BW-1:0];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			stage_rp_q <= '0;
			stage_pp_q <= '0;
			new_slot_q <= '0;
			bc_q       <= '0;
			copy_v_s1  <= 1'b0;
			step_q     <= '0;
			pv_q       <= '0;
			nx_q       <= '0;
			mc_q       <= '0;
			mul_v_s1   <= 1'b0;
			res_q      <= '0;
			valid_q    <= 1'b0;
		end else begin
			valid_q   <= 1'b0;
			copy_v_s1 <= 1'b0;
			mul_v_s1  <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						res_q <= '0;
						unique case (cmd.op)
							OP_COMMIT: begin
								if (count_q == CW'(MAX_KEYS)) begin
									res_q.status <= STAT_FULL;
									stage_rp_q   <= '0;
									stage_pp_q   <= '0;
									valid_q      <= 1'b1;
								end else begin
									new_slot_q <= KW'(count_q);
									state_q    <= S_CM_INS;
								end
							end
							OP_STAGE_ROT: begin
								if (cmd.bone_ok) begin
									stage_rp_q[bone_in] <= 1'b1;
								end
								valid_q <= 1'b1;
							end
							OP_STAGE_POS: begin
								if (cmd.bone_ok) begin
									stage_pp_q[bone_in] <= 1'b1;
								end
								valid_q <= 1'b1;
							end
							OP_SAMPLE: begin
								if (count_q == '0) begin
									res_q.status <= STAT_NOKEY;
									valid_q      <= 1'b1;
								end else if (!cmd.bone_ok) begin
									res_q.status <= STAT_NOROT;
									valid_q      <= 1'b1;
								end else if (loop_enable && dur_w > 0) begin
									step_q  <= '0;
									state_q <= S_MOD;
								end else begin
									state_q <= S_CLAMP;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CM_INS: begin
					bc_q    <= '0;
					state_q <= S_CM_COPY;
				end
				S_CM_COPY: begin
					if (bc_q < (BW+1)'(MAX_BONES)) begin
						copy_v_s1 <= 1'b1;
						bc_q      <= bc_q + (BW+1)'(1);
					end else if (copy_v_s1) begin
						count_q    <= count_q + CW'(1);
						stage_rp_q <= '0;
						stage_pp_q <= '0;
						valid_q    <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_MOD: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd31) begin
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					if (tm_c <= time_row_q[0]) begin
						pv_q    <= '0;
						nx_q    <= '0;
						state_q <= S_RD0;
					end else if (tm_c >= dur_q) begin
						pv_q    <= cnt_m1;
						nx_q    <= cnt_m1;
						state_q <= S_RD0;
					end else begin
						pv_q    <= '0;
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if ((CW'(pv_q) + CW'(1)) < count_q && time_row_q[pv_inc] <= tm_q) begin
						pv_q <= pv_inc;
					end else begin
						nx_q    <= pv_inc;
						state_q <= S_RD0;
					end
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_RD2;
				S_RD2: begin
					if (!key_a_q[KEY_W-1] && !key_b[KEY_W-1]) begin
						res_q.status <= STAT_NOROT;
						valid_q      <= 1'b1;
						state_q      <= S_IDLE;
					end else if (span_w > 0) begin
						step_q  <= '0;
						state_q <= S_DIV;
					end else begin
						mc_q    <= '0;
						state_q <= S_MUL;
					end
				end
				S_DIV: begin
					step_q <= step_q + 6'd1;
					if (step_q == 6'd15) begin
						mc_q    <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mc_q < 3'd6) begin
						mul_v_s1 <= 1'b1;
						mc_q     <= mc_q + 3'd1;
					end
					if (mul_v_s1) begin
						case (comp_s1)
							3'd0: res_q.rot_x <= pick_out(pick_s1, a_s1, b_s1, lerp_w);
							3'd1: res_q.rot_y <= pick_out(pick_s1, a_s1, b_s1, lerp_w);
							3'd2: res_q.rot_z <= pick_out(pick_s1, a_s1, b_s1, lerp_w);
							3'd3: res_q.pos_x <= pick_out(pick_s1, a_s1, b_s1, lerp_w);
							3'd4: res_q.pos_y <= pick_out(pick_s1, a_s1, b_s1, lerp_w);
							default: res_q.pos_z <= pick_out(pick_s1, a_s1, b_s1, lerp_w);
						endcase
						if (comp_s1 == 3'd5) begin
							valid_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Both keys hold the vector: blend. One key: take it. Neither: zero.
	function automatic logic signed [31:0] pick_out(input logic [1:0] p,
			input logic signed [31:0] a, input logic signed [31:0] b,
			input logic signed [31:0] l);
		logic signed [31:0] v;
		case (p)
			2'b11:   v = l;
			2'b10:   v = a;
			2'b01:   v = b;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign result_valid = valid_q;
	assign result       = res_q;

`ifndef SYNTH
	a_result_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> state_q == S_IDLE) else $error("result strobe while sequencer busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_KEYS)) else $error("key count beyond table size");
	a_copy_in_commit: assert property (@(posedge clk) disable iff (!arst_n)
		kram_we |-> state_q == S_CM_COPY) else $error("key write outside commit");
	a_count_moves_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(state_q) == S_CM_COPY)
		else $error("key count changed outside commit");
`endif

endmodule

[rtl/core/keyframe_bone_sampler_top.sv]
// Top level of the keyframe bone sampler: register port, front end and back end.
// Depends on kbs_pkg, kbs_front, kbs_back (and kbs_ram through kbs_back).
//
//   channel   | signals                               | handshake
//   ----------+---------------------------------------+----------------------------
//   command   | cmd (in_word_t)                       | start high, busy low
//   result    | result (out_word_t)                   | result_valid, one cycle
//   register  | psel penable pwrite paddr pwdata prdata| APB, pready always high
//
// A stage word is answered from the idle state without entering the sequencer. A
// commit runs a sweep that copies the staging frame into the key memory one bone
// per cycle. A sample wraps the time when looping is on, clamps it, finds the
// bracketing keys, divides out the fraction and runs the six blends on one
// shared multiplier.
// After reset the key table is empty and the staging frame holds no vectors.
// The front queue holds two words, so busy rises only when the back end is
// working on one word with two more waiting. Results cannot be stalled.
module keyframe_bone_sampler_top
	import kbs_pkg::*;
#(
	parameter int MAX_KEYS  = DEF_MAX_KEYS,
	parameter int MAX_BONES = DEF_MAX_BONES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_word_t    cmd,
	output logic        result_valid,
	output out_word_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic loop_q;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	// The loop enable register is the only one; unaligned addresses are ignored.
	assign pready = 1'b1;
	assign prdata = (paddr == REG_LOOP_ADDR) ? {31'd0, loop_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr == REG_LOOP_ADDR) begin
			loop_q <= pwdata[0];
		end
	end

	kbs_front #(.MAX_BONES(MAX_BONES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd_out   (q_cmd)
	);

	kbs_back #(.MAX_KEYS(MAX_KEYS), .MAX_BONES(MAX_BONES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.loop_enable  (loop_q),
		.cmd_valid    (q_valid),
		.cmd_ready    (q_ready),
		.cmd          (q_cmd),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

[tb/keyframe_bone_sampler_top_tb.sv]
// Self-checking testbench for keyframe_bone_sampler_top: staging, commits, sampling.
// Depends on kbs_pkg and the RTL of the sampler. It drives random words and
// register writes, predicts each result in place and compares it field by field.
`timescale 1ns / 1ps

module keyframe_bone_sampler_top_tb;
	import kbs_pkg::*;

	localparam int N_KEYS     = DEF_MAX_KEYS;
	localparam int N_BONES    = DEF_MAX_BONES;
	// Comfortably above the slowest correct run of the whole test.
	localparam int CYCLE_LIMIT = 600000;
	// Margin after the last result that covers any word still in flight.
	localparam int DRAIN_CYCLES = 120;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_word_t    cmd;
	logic        result_valid;
	out_word_t   result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	keyframe_bone_sampler_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.result_valid(result_valid), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Shadow copy of the clip table, the staging frame and the loop setting.
	bit                 loop_on;
	int                 n_keys;
	longint             key_time [N_KEYS];
	bit                 key_rot_p [N_KEYS][N_BONES];
	bit                 key_pos_p [N_KEYS][N_BONES];
	logic signed [31:0] key_rot [N_KEYS][N_BONES][3];
	logic signed [31:0] key_pos [N_KEYS][N_BONES][3];
	bit                 stg_rot_p [N_BONES];
	bit                 stg_pos_p [N_BONES];
	logic signed [31:0] stg_rot [N_BONES][3];
	logic signed [31:0] stg_pos [N_BONES][3];

	out_word_t pending_results[$];
	int        mismatches;
	int        cycles;
	bit        gaps_on;

	// Linear blend with the product floored, as the fixed-point datapath does.
	function automatic logic signed [31:0] blend(longint a, longint b, longint t);
		longint p;
		p = (b - a) * t;
		return 32'(a + (p >>> 16));
	endfunction

	// Updates the shadow state for one accepted word and queues its result.
	task automatic apply_word(input in_word_t w);
		out_word_t r;
		int        p, pv, nx, b, i;
		longint    dur, tm, span, t;
		bit        rp, rn, pp, pn;
		r = '0;
		case (op_t'(w.func))
			OP_COMMIT: begin
				if (n_keys >= N_KEYS) begin
					r.status = STAT_FULL;
				end else begin
					p = n_keys;
					// Later keys move up so that equal times keep their order.
					while (p > 0 && key_time[p-1] > longint'(w.time_value)) begin
						key_time[p]  = key_time[p-1];
						key_rot_p[p] = key_rot_p[p-1];
						key_pos_p[p] = key_pos_p[p-1];
						key_rot[p]   = key_rot[p-1];
						key_pos[p]   = key_pos[p-1];
						p--;
					end
					key_time[p]  = longint'(w.time_value);
					key_rot_p[p] = stg_rot_p;
					key_pos_p[p] = stg_pos_p;
					key_rot[p]   = stg_rot;
					key_pos[p]   = stg_pos;
					n_keys++;
				end
				for (b = 0; b < N_BONES; b++) begin
					stg_rot_p[b] = 1'b0;
					stg_pos_p[b] = 1'b0;
				end
			end
			OP_STAGE_ROT: begin
				stg_rot_p[w.bone_index] = 1'b1;
				stg_rot[w.bone_index]   = '{w.vec_x, w.vec_y, w.vec_z};
			end
			OP_STAGE_POS: begin
				stg_pos_p[w.bone_index] = 1'b1;
				stg_pos[w.bone_index]   = '{w.vec_x, w.vec_y, w.vec_z};
			end
			default: begin
				if (n_keys == 0) begin
					r.status = STAT_NOKEY;
				end else begin
					dur = key_time[n_keys-1];
					tm  = longint'(w.time_value);
					// Wrap truncates toward zero, then the time is clamped.
					if (loop_on && dur > 0)
						tm = tm % dur;
					if (tm < 0)
						tm = 0;
					if (tm > dur)
						tm = dur;
					if (tm <= key_time[0]) begin
						pv = 0;
						nx = 0;
					end else if (tm >= dur) begin
						pv = n_keys - 1;
						nx = n_keys - 1;
					end else begin
						pv = 0;
						while (pv + 1 < n_keys && key_time[pv+1] <= tm)
							pv++;
						nx = pv + 1;
					end
					rp = key_rot_p[pv][w.bone_index];
					rn = key_rot_p[nx][w.bone_index];
					pp = key_pos_p[pv][w.bone_index];
					pn = key_pos_p[nx][w.bone_index];
					if (!rp && !rn) begin
						r.status = STAT_NOROT;
					end else begin
						r.status = STAT_OK;
						t    = 0;
						span = key_time[nx] - key_time[pv];
						if (span > 0)
							t = ((tm - key_time[pv]) << 16) / span;
						for (i = 0; i < 3; i++) begin
							logic signed [31:0] rv, pvv;
							rv  = 0;
							pvv = 0;
							if (rp && rn)
								rv = blend(key_rot[pv][w.bone_index][i],
									key_rot[nx][w.bone_index][i], t);
							else if (rp)
								rv = key_rot[pv][w.bone_index][i];
							else
								rv = key_rot[nx][w.bone_index][i];
							// A position missing from both keys reads as zero.
							if (pp && pn)
								pvv = blend(key_pos[pv][w.bone_index][i],
									key_pos[nx][w.bone_index][i], t);
							else if (pp)
								pvv = key_pos[pv][w.bone_index][i];
							else if (pn)
								pvv = key_pos[nx][w.bone_index][i];
							case (i)
								0: begin
									r.rot_x = rv;
									r.pos_x = pvv;
								end
								1: begin
									r.rot_y = rv;
									r.pos_y = pvv;
								end
								default: begin
									r.rot_z = rv;
									r.pos_z = pvv;
								end
							endcase
						end
					end
				end
			end
		endcase
		pending_results = {pending_results, r};
	endtask

	// Every result is checked against the oldest outstanding prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			out_word_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", result);
			end else begin
				want = pending_results.pop_front();
				if (want.status !== result.status || want.rot_x !== result.rot_x ||
					want.rot_y !== result.rot_y || want.rot_z !== result.rot_z ||
					want.pos_x !== result.pos_x || want.pos_y !== result.pos_y ||
					want.pos_z !== result.pos_z) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected st=%0d rot=%h %h %h pos=%h %h %h",
							want.status, want.rot_x, want.rot_y, want.rot_z,
							want.pos_x, want.pos_y, want.pos_z);
						$display("          actual   st=%0d rot=%h %h %h pos=%h %h %h",
							result.status, result.rot_x, result.rot_y, result.rot_z,
							result.pos_x, result.pos_y, result.pos_z);
					end
				end
			end
		end
	end

	// The watchdog ends a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Presents one word, holds it until the block takes it, then maybe idles.
	// start stays high when the next word follows right away.
	task automatic send_word(input in_word_t w);
		int n;
		cmd   = w;
		start = 1'b1;
		do
			@(posedge clk);
		while (busy);
		apply_word(w);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			n = $urandom_range(1, 11);
			repeat (n) @(negedge clk);
		end
	endtask

	function automatic in_word_t make_word(op_t op, logic signed [31:0] tv,
		logic [3:0] bone, logic signed [31:0] x, logic signed [31:0] y,
		logic signed [31:0] z);
		in_word_t w;
		w.func       = op;
		w.time_value = tv;
		w.bone_index = bone;
		w.vec_x      = x;
		w.vec_y      = y;
		w.vec_z      = z;
		return w;
	endfunction

	// Waits until every predicted result has come back and the block is idle.
	task automatic wait_idle();
		start = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes loop_enable through the register port, setup then access cycle.
	task automatic write_loop(input bit val);
		wait_idle();
		psel    = 1'b1;
		pwrite  = 1'b1;
		paddr   = REG_LOOP_ADDR;
		pwdata  = {31'(0), val};
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		loop_on = val;
	endtask

	function automatic logic signed [31:0] rand_vec();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom();
			default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
		endcase
	endfunction

	// Times are mostly a few seconds around the clip, sometimes anything at all.
	function automatic logic signed [31:0] rand_time();
		if ($urandom_range(0, 9) == 0)
			return $urandom();
		return $signed($urandom_range(0, 32'h0018_0000)) - 32'sh0002_0000;
	endfunction

	// Directed words: empty table, extremes, equal times, missing vectors, wrap.
	task automatic test_directed();
		send_word(make_word(OP_SAMPLE, 32'sd0, 4'd0, 0, 0, 0));
		send_word(make_word(OP_STAGE_ROT, 0, 4'd15, 32'sh7fffffff, 32'sh80000000, 32'sd1));
		send_word(make_word(OP_STAGE_POS, 0, 4'd15, 32'sh80000000, 32'sh7fffffff, -32'sd1));
		send_word(make_word(OP_STAGE_ROT, 0, 4'd0, 32'sh0001_0000, 0, -32'sh0001_0000));
		send_word(make_word(OP_COMMIT, 32'sh0001_0000, 4'd0, 0, 0, 0));
		send_word(make_word(OP_STAGE_ROT, 0, 4'd15, 32'sh80000000, 32'sh7fffffff, -32'sd7));
		send_word(make_word(OP_STAGE_POS, 0, 4'd0, 32'sh0003_0000, 32'sd5, 32'sd9));
		send_word(make_word(OP_COMMIT, 32'sh0003_0000, 4'd0, 0, 0, 0));
		// An equal time lands after the existing key, an earlier one before it.
		send_word(make_word(OP_STAGE_ROT, 0, 4'd3, 32'sd100, 32'sd200, 32'sd300));
		send_word(make_word(OP_COMMIT, 32'sh0003_0000, 4'd0, 0, 0, 0));
		send_word(make_word(OP_STAGE_ROT, 0, 4'd0, -32'sh0005_0000, 32'sd3, 32'sd4));
		send_word(make_word(OP_COMMIT, -32'sh0001_0000, 4'd0, 0, 0, 0));
		send_word(make_word(OP_SAMPLE, 32'sh80000000, 4'd15, 0, 0, 0));
		send_word(make_word(OP_SAMPLE, 32'sh7fffffff, 4'd15, 0, 0, 0));
		send_word(make_word(OP_SAMPLE, 32'sh0002_8000, 4'd15, 0, 0, 0));
		send_word(make_word(OP_SAMPLE, 32'sh0000_4000, 4'd0, 0, 0, 0));
		send_word(make_word(OP_SAMPLE, 32'sh0002_0000, 4'd3, 0, 0, 0));
		send_word(make_word(OP_SAMPLE, 32'sh0001_0000, 4'd7, 0, 0, 0));
		write_loop(1'b1);
		send_word(make_word(OP_SAMPLE, 32'sh0004_8000, 4'd15, 0, 0, 0));
		send_word(make_word(OP_SAMPLE, -32'sh0004_8000, 4'd0, 0, 0, 0));
		send_word(make_word(OP_SAMPLE, 32'sh7fffffff, 4'd0, 0, 0, 0));
		write_loop(1'b0);
	endtask

	// Random words, weighted so that the table fills up over the whole run.
	task automatic test_random(input int n_words);
		int       k, sel;
		in_word_t w;
		for (k = 0; k < n_words; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 6)
				w = make_word(OP_COMMIT, rand_time(), 4'($urandom()), 0, 0, 0);
			else if (sel < 36)
				w = make_word(OP_STAGE_ROT, $urandom(), 4'($urandom()),
					rand_vec(), rand_vec(), rand_vec());
			else if (sel < 56)
				w = make_word(OP_STAGE_POS, $urandom(), 4'($urandom()),
					rand_vec(), rand_vec(), rand_vec());
			else
				w = make_word(OP_SAMPLE, rand_time(), 4'($urandom()), 0, 0, 0);
			send_word(w);
		end
	endtask

	// Once the table is full, further commits must report it and drop the frame.
	task automatic test_full_table();
		while (n_keys < N_KEYS) begin
			send_word(make_word(OP_STAGE_ROT, 0, 4'($urandom()), rand_vec(),
				rand_vec(), rand_vec()));
			send_word(make_word(OP_COMMIT, rand_time(), 4'd0, 0, 0, 0));
		end
		send_word(make_word(OP_STAGE_POS, 0, 4'd2, 32'sd1, 32'sd2, 32'sd3));
		send_word(make_word(OP_COMMIT, 32'sh0001_0000, 4'd0, 0, 0, 0));
		send_word(make_word(OP_COMMIT, 32'sh7fffffff, 4'd0, 0, 0, 0));
		test_random(60);
	endtask

	initial begin
		arst_n  = 1'b0;
		start   = 1'b0;
		cmd     = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		loop_on = 1'b0;
		n_keys  = 0;
		gaps_on = 1'b1;
		mismatches = 0;
		cycles  = 0;
		for (int b = 0; b < N_BONES; b++) begin
			stg_rot_p[b] = 1'b0;
			stg_pos_p[b] = 1'b0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(250);
		write_loop(1'b1);
		test_random(250);
		write_loop(1'b0);
		test_random(160);
		write_loop(1'b1);
		// The tail of the run goes without any idle gaps.
		gaps_on = 1'b0;
		test_full_table();

		wait_idle();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
